/* rtl/dtoi_pkg.sv */
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and constants of the decimal text to integer converter.
// ----------------------------------------------------------------------------
package dtoi_pkg;

  // widest running value of the last digits: 10 digits stay below 2^34
  localparam int PSUM_W  = 34;
  localparam int DIGIT_W = 4;
  localparam int VALUE_W = 33;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // configuration register indexes
  localparam logic CFG_PARSE_MODE = 1'b0;
  localparam logic CFG_SIGNED     = 1'b1;

  typedef enum logic [1:0] {
    MODE_STRICT = 2'd0,
    MODE_SPACES = 2'd1,
    MODE_FIRST  = 2'd2,
    MODE_LAST   = 2'd3
  } dtoi_mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ILLEGAL = 3'd1,
    ST_NONUM   = 3'd2,
    ST_OVER    = 3'd3,
    ST_UNDER   = 3'd4
  } dtoi_status_t;

  // text-level state handed from the scanner to the weighing stage
  typedef struct packed {
    logic              negative;
    logic              signed_mode;
    dtoi_status_t      error_code;
    logic [CHAR_W-1:0] bad_char;
  } dtoi_ctl_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    dtoi_status_t       status;
    logic [CHAR_W-1:0]  offending_char;
  } dtoi_result_t;

endpackage

/* rtl/dtoi_scan.sv */
// ----------------------------------------------------------------------------
// dtoi_scan
// Per-character text state: classifies each character, keeps the last digits,
// the running values of the last digits, the count, the sign and the error.
// ----------------------------------------------------------------------------
module dtoi_scan #(
  parameter int MAX_DIGITS = 10,
  localparam int CW = $clog2(MAX_DIGITS + 2)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [dtoi_pkg::CHAR_W-1:0]       character,
  input  logic                              no_char,
  input  logic                              end_text,
  input  dtoi_pkg::dtoi_mode_t              parse_mode,
  input  logic                              signed_result,
  output logic [dtoi_pkg::DIGIT_W-1:0]      snap_digits [MAX_DIGITS],
  output logic [dtoi_pkg::PSUM_W-1:0]       snap_psum [MAX_DIGITS],
  output logic [CW-1:0]                     snap_count,
  output dtoi_pkg::dtoi_ctl_t               snap_ctl
);

  localparam int PW = dtoi_pkg::PSUM_W;

  logic [dtoi_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [PW-1:0]                psum [MAX_DIGITS];
  logic [CW-1:0]                count;
  logic                         negative;
  logic                         gap_seen;
  logic                         finished;
  dtoi_pkg::dtoi_status_t       error_code;
  logic [dtoi_pkg::CHAR_W-1:0]  bad_char;

  logic [CW-1:0]                count_next;
  logic                         negative_next;
  logic                         gap_seen_next;
  logic                         finished_next;
  dtoi_pkg::dtoi_status_t       error_code_next;
  logic [dtoi_pkg::CHAR_W-1:0]  bad_char_next;
  logic                         shift_in;

  logic [dtoi_pkg::CHAR_W-1:0]  offset;
  logic [dtoi_pkg::DIGIT_W-1:0] digit;
  logic                         is_digit;
  logic                         is_minus;
  logic [CW-1:0]                count_base;

  assign offset   = character - dtoi_pkg::CH_ZERO;
  assign digit    = offset[dtoi_pkg::DIGIT_W-1:0];
  assign is_digit = (character >= dtoi_pkg::CH_ZERO) && (character <= dtoi_pkg::CH_NINE);
  assign is_minus = signed_result && (character == dtoi_pkg::CH_MINUS);

  always_comb begin
    count_next      = count;
    negative_next   = negative;
    gap_seen_next   = gap_seen;
    finished_next   = finished;
    error_code_next = error_code;
    bad_char_next   = bad_char;
    shift_in        = 1'b0;
    count_base      = gap_seen ? '0 : count;
    if (!no_char && error_code == dtoi_pkg::ST_OK && !finished) begin
      if (is_minus) begin
        if (count != '0) begin
          error_code_next = dtoi_pkg::ST_ILLEGAL;
          bad_char_next   = character;
        end else begin
          negative_next = !negative;
        end
      end else if (!is_digit) begin
        case (parse_mode)
          dtoi_pkg::MODE_FIRST: begin
            if (count != '0) begin
              finished_next = 1'b1;
            end
          end
          dtoi_pkg::MODE_LAST: begin
            gap_seen_next = 1'b1;
          end
          dtoi_pkg::MODE_SPACES: begin
            if (character != dtoi_pkg::CH_SPACE) begin
              error_code_next = dtoi_pkg::ST_ILLEGAL;
              bad_char_next   = character;
            end
          end
          default: begin
            // strict
            error_code_next = dtoi_pkg::ST_ILLEGAL;
            bad_char_next   = character;
          end
        endcase
      end else begin
        shift_in = 1'b1;
        // a digit after a gap starts a new number
        if (gap_seen) begin
          gap_seen_next = 1'b0;
          negative_next = 1'b0;
        end
        count_next = (count_base <= CW'(MAX_DIGITS)) ? count_base + CW'(1) : count_base;
      end
    end
  end

  // each entry is the value of the latest i+1 digits
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      snap_digits[i] = digits[i];
      snap_psum[i]   = psum[i];
    end
    if (shift_in) begin
      snap_digits[0] = digit;
      snap_psum[0]   = PW'(digit);
      for (int i = 1; i < MAX_DIGITS; i++) begin
        snap_digits[i] = digits[i-1];
        snap_psum[i]   = (psum[i-1] << 3) + (psum[i-1] << 1) + PW'(digit);
      end
    end
  end

  assign snap_count = count_next;
  assign snap_ctl   = '{negative:    negative_next,
                        signed_mode: signed_result,
                        error_code:  error_code_next,
                        bad_char:    bad_char_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      negative   <= 1'b0;
      gap_seen   <= 1'b0;
      finished   <= 1'b0;
      error_code <= dtoi_pkg::ST_OK;
      bad_char   <= '0;
    end else if (take) begin
      if (end_text) begin
        count      <= '0;
        negative   <= 1'b0;
        gap_seen   <= 1'b0;
        finished   <= 1'b0;
        error_code <= dtoi_pkg::ST_OK;
        bad_char   <= '0;
      end else begin
        count      <= count_next;
        negative   <= negative_next;
        gap_seen   <= gap_seen_next;
        finished   <= finished_next;
        error_code <= error_code_next;
        bad_char   <= bad_char_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digits <= snap_digits;
      psum   <= snap_psum;
    end
  end

  a_clear_at_end: assert property (@(posedge clk) disable iff (rst)
    take && end_text |=> count == '0 && error_code == dtoi_pkg::ST_OK && !finished)
    else $error("text state not cleared after end of text");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_DIGITS + 1))
    else $error("digit count beyond saturation");

  a_error_held: assert property (@(posedge clk) disable iff (rst)
    error_code != dtoi_pkg::ST_OK && !(take && end_text)
    |=> error_code == dtoi_pkg::ST_ILLEGAL && $stable(bad_char))
    else $error("latched illegal character lost within a text");

endmodule

/* rtl/dtoi_weigh.sv */
// ----------------------------------------------------------------------------
// dtoi_weigh
// Range checks of a finished text: finds the first digit position whose
// digit or running sum leaves the range, and forms value and status.
// ----------------------------------------------------------------------------
module dtoi_weigh #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10,
  localparam int CW = $clog2(MAX_DIGITS + 2)
) (
  input  logic [dtoi_pkg::DIGIT_W-1:0] digits [MAX_DIGITS],
  input  logic [dtoi_pkg::PSUM_W-1:0]  psum [MAX_DIGITS],
  input  logic [CW-1:0]                count,
  input  dtoi_pkg::dtoi_ctl_t          ctl,
  output dtoi_pkg::dtoi_result_t       result
);

  localparam int PW = dtoi_pkg::PSUM_W;
  localparam int VW = dtoi_pkg::VALUE_W;

  // largest digit d with d * 10^pos <= m
  function automatic logic [3:0] dig_limit(input logic [PW-1:0] m, input int pos);
    logic [39:0] p;
    logic [3:0]  lim;
    p   = 40'd1;
    lim = '0;
    for (int k = 0; k < pos; k++) begin
      p = p * 40'd10;
    end
    for (int d = 1; d < 10; d++) begin
      if (40'(d) * p <= 40'(m)) begin
        lim = 4'(d);
      end
    end
    return lim;
  endfunction

  // first position j with 10^(j+1) > m; the weight cannot grow past it
  function automatic int first_big(input logic [PW-1:0] m);
    logic [39:0] p;
    int          j;
    logic        found;
    p     = 40'd10;
    j     = 0;
    found = 1'b0;
    for (int k = 0; k < 11; k++) begin
      if (!found && p > 40'(m)) begin
        j     = k;
        found = 1'b1;
      end
      p = p * 40'd10;
    end
    return j;
  endfunction

  localparam logic [PW-1:0] MAXV_S = (PW'(1) << (VALUE_WIDTH - 1)) - PW'(1);
  localparam logic [PW-1:0] MAXV_U = (PW'(1) << VALUE_WIDTH) - PW'(1);
  localparam int            J_S    = first_big(MAXV_S);
  localparam int            J_U    = first_big(MAXV_U);

  logic                  neg_eff;
  logic [PW-1:0]         lim;
  logic [MAX_DIGITS-1:0] dov;
  logic [MAX_DIGITS-1:0] hit;

  assign neg_eff = ctl.signed_mode && ctl.negative;
  assign lim     = ctl.signed_mode ? (neg_eff ? MAXV_S + PW'(1) : MAXV_S) : MAXV_U;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_pos
    localparam logic [3:0] LIM_S  = dig_limit(MAXV_S, i);
    localparam logic [3:0] LIM_U  = dig_limit(MAXV_U, i);
    localparam logic       REACH_S = (i <= J_S);
    localparam logic       REACH_U = (i <= J_U);
    logic in_range;
    logic sov;
    assign dov[i]   = ctl.signed_mode ? (digits[i] > LIM_S) : (digits[i] > LIM_U);
    assign sov      = psum[i] > lim;
    assign in_range = (int'(count) > i) && (ctl.signed_mode ? REACH_S : REACH_U);
    assign hit[i]   = in_range && (dov[i] || sov);
  end

  logic          found;
  logic          first_dov;
  logic [VW-1:0] mag;
  int            jlim;

  always_comb begin
    found     = 1'b0;
    first_dov = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (!found && hit[i]) begin
        found     = 1'b1;
        first_dov = dov[i];
      end
    end
    mag = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (count == CW'(i + 1)) begin
        mag = psum[i][VW-1:0];
      end
    end
    jlim = ctl.signed_mode ? J_S : J_U;

    result.value          = '0;
    result.status         = dtoi_pkg::ST_OK;
    result.offending_char = '0;
    if (ctl.error_code != dtoi_pkg::ST_OK) begin
      result.status         = ctl.error_code;
      result.offending_char = ctl.bad_char;
    end else if (count == '0) begin
      result.status = dtoi_pkg::ST_NONUM;
    end else if (int'(count) > MAX_DIGITS) begin
      result.status = dtoi_pkg::ST_OVER;
    end else if (found) begin
      // a single digit too large counts as overflow even for negative numbers
      result.status = (first_dov || !neg_eff) ? dtoi_pkg::ST_OVER : dtoi_pkg::ST_UNDER;
    end else if (int'(count) > jlim + 1) begin
      result.status = dtoi_pkg::ST_OVER;
    end else begin
      result.value = neg_eff ? VW'(0) - mag : mag;
    end
  end

endmodule

/* rtl/decimal_text_to_integer_core.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_integer_core
// Decimal text to integer converter with overflow and underflow checks.
// ----------------------------------------------------------------------------
// The text arrives one character per request on the s_axis channel; tuser
// marks a request that carries no character and tlast marks the final one.
// Only the final request of a text yields a result on the m_axis channel:
// the value (zero unless status is ok), the status and, for an illegal
// character, that character.
// A request is taken in every cycle while the pipeline has room, so the
// sustained rate is one character per cycle. The final character of a text
// is registered into the range check stage together with the digit window
// that the scanner updates, and its result then into the output register.
// When m_axis_tready is low the result waits in the output register and the
// range check stage still holds one more text; characters of the next text
// are taken until that stage is full.
// Reset clears all text state and the pipeline, sets parse_mode to strict
// and signed results on. The user writes configuration through cfg_we,
// cfg_index and cfg_data while no text is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tuser,   // [0] no_char
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [32:0] value, [40:33] offending_char, zero above
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_DIGITS + 2);

  dtoi_pkg::dtoi_mode_t           parse_mode;
  logic                           signed_result;

  logic                           take;
  logic                           out_free;
  logic                           s1_move;

  logic [dtoi_pkg::DIGIT_W-1:0]   snap_digits [MAX_DIGITS];
  logic [dtoi_pkg::PSUM_W-1:0]    snap_psum [MAX_DIGITS];
  logic [CW-1:0]                  snap_count;
  dtoi_pkg::dtoi_ctl_t            snap_ctl;

  logic                           s1_valid;
  logic [dtoi_pkg::DIGIT_W-1:0]   s1_digits [MAX_DIGITS];
  logic [dtoi_pkg::PSUM_W-1:0]    s1_psum [MAX_DIGITS];
  logic [CW-1:0]                  s1_count;
  dtoi_pkg::dtoi_ctl_t            s1_ctl;

  dtoi_pkg::dtoi_result_t         weigh_result;
  logic                           m_valid;
  dtoi_pkg::dtoi_result_t         m_result;

  assign out_free      = !m_valid || m_axis_tready;
  assign s1_move       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= dtoi_pkg::MODE_STRICT;
      signed_result <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == dtoi_pkg::CFG_PARSE_MODE) begin
        parse_mode <= dtoi_pkg::dtoi_mode_t'(cfg_data);
      end else begin
        signed_result <= cfg_data[0];
      end
    end
  end

  dtoi_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .character     (s_axis_tdata),
    .no_char       (s_axis_tuser),
    .end_text      (s_axis_tlast),
    .parse_mode    (parse_mode),
    .signed_result (signed_result),
    .snap_digits   (snap_digits),
    .snap_psum     (snap_psum),
    .snap_count    (snap_count),
    .snap_ctl      (snap_ctl)
  );

  // range check stage, loaded by the final character of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take && s_axis_tlast) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_axis_tlast) begin
      s1_digits <= snap_digits;
      s1_psum   <= snap_psum;
      s1_count  <= snap_count;
      s1_ctl    <= snap_ctl;
    end
  end

  dtoi_weigh #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_weigh (
    .digits (s1_digits),
    .psum   (s1_psum),
    .count  (s1_count),
    .ctl    (s1_ctl),
    .result (weigh_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s1_move) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_result <= weigh_result;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'b0, m_result.offending_char, m_result.value};
  assign m_axis_tuser  = m_result.status;

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != dtoi_pkg::ST_OK |-> m_axis_tdata[32:0] == '0)
    else $error("nonzero value with error status");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != dtoi_pkg::ST_ILLEGAL |-> m_axis_tdata[40:33] == '0)
    else $error("offending character without illegal status");

  a_stage_load: assert property (@(posedge clk) disable iff (rst)
    $rose(s1_valid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("range check stage loaded without final character");

endmodule
